@@ hdl/bspv_pkg.sv @@
package bspv_pkg;

   localparam int DataWidth = 32;
   localparam int CapWidth  = 9;
   localparam int ModeWidth = 2;
   localparam int IdxWidth  = 3;

   typedef enum logic [ModeWidth-1:0] {
      MODE_NONE  = 2'd0,
      MODE_RANGE = 2'd1,
      MODE_MONO  = 2'd2
   } mode_type;

   typedef enum logic [IdxWidth-1:0] {
      REG_VALIDATE_MODE = 3'd0,
      REG_RANGE_MIN     = 3'd1,
      REG_RANGE_MAX     = 3'd2,
      REG_CAPACITY      = 3'd3,
      REG_FLOOR_START   = 3'd4
   } reg_index_type;

   // push/pop shift control broadcast along the cell row
   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

   // validator settings and tracked floor
   typedef struct packed {
      logic [ModeWidth-1:0]        mode;
      logic signed [DataWidth-1:0] range_min;
      logic signed [DataWidth-1:0] range_max;
      logic signed [DataWidth-1:0] last_accepted;
   } check_type;

endpackage

@@ hdl/bspv_if.sv @@
interface bspv_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  op;
   logic signed [bspv_pkg::DataWidth-1:0] push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface bspv_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  ok;
   logic signed [bspv_pkg::DataWidth-1:0] popped_value;
   logic [bspv_pkg::CapWidth-1:0]         depth_after;

   modport source (output valid, output ok, output popped_value, output depth_after,
                   input ready);
   modport sink   (input valid, input ok, input popped_value, input depth_after,
                   output ready);
endinterface

@@ hdl/bspv_cell.sv @@
module bspv_cell (
   input  logic                                  clock,
   input  bspv_pkg::shift_type                   shift,
   input  logic signed [bspv_pkg::DataWidth-1:0] above_in,
   input  logic signed [bspv_pkg::DataWidth-1:0] below_in,
   output logic signed [bspv_pkg::DataWidth-1:0] value
);

   logic signed [bspv_pkg::DataWidth-1:0] value_ff;
   logic signed [bspv_pkg::DataWidth-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (shift.push) begin
         value_in = above_in;
      end else if (shift.pop) begin
         value_in = below_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ hdl/bspv_validate.sv @@
module bspv_validate (
   input  bspv_pkg::check_type                   check,
   input  logic signed [bspv_pkg::DataWidth-1:0] value,
   output logic                                  pass
);

   always_comb begin
      case (check.mode)
         bspv_pkg::MODE_RANGE: pass = (value >= check.range_min) &&
                                      (value <= check.range_max);
         bspv_pkg::MODE_MONO:  pass = (value >= check.last_accepted);
         default:              pass = 1'b1;  // includes the unused mode code
      endcase
   end

endmodule

@@ hdl/bounded_stack_with_push_validation.sv @@
// Channel  Dir  Handshake          Beat payload
// req_bus  in   valid/ready        op, push_value
// rsp_bus  out  valid/ready        ok, popped_value, depth_after
// csr_*    in   csr_we, no ready   csr_index, csr_wdata
//
// One request per cycle unless stalled; its response is registered the next cycle.
// The stack is a row of DEPTH cells that shift down on push and up on pop; the
// top entry always sits in cell 0, so a pop reads a fixed place.
// req_bus.ready drops only while a response is held and rsp_bus.ready is low.
// Sync reset clears count and rsp valid, presets floor, CSRs; cells hold no reset.
module bounded_stack_with_push_validation #(
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bspv_req_if.sink                             req_bus,
   bspv_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [bspv_pkg::IdxWidth-1:0]        csr_index,
   input  logic [bspv_pkg::DataWidth-1:0]       csr_wdata
);

   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam int CmpWidth   = (CountWidth > bspv_pkg::CapWidth) ?
                               CountWidth : bspv_pkg::CapWidth;

   localparam logic signed [bspv_pkg::DataWidth-1:0] MinValue =
      {1'b1, {(bspv_pkg::DataWidth-1){1'b0}}};
   localparam logic signed [bspv_pkg::DataWidth-1:0] MaxValue =
      {1'b0, {(bspv_pkg::DataWidth-1){1'b1}}};

   logic [bspv_pkg::ModeWidth-1:0]        mode_ff;
   logic signed [bspv_pkg::DataWidth-1:0] range_min_ff;
   logic signed [bspv_pkg::DataWidth-1:0] range_max_ff;
   logic [bspv_pkg::CapWidth-1:0]         capacity_ff;
   logic signed [bspv_pkg::DataWidth-1:0] last_ff;
   logic signed [bspv_pkg::DataWidth-1:0] last_in;
   logic [CountWidth-1:0]                 top_ff;
   logic [CountWidth-1:0]                 top_in;

   logic                                  rsp_valid_ff;
   logic                                  rsp_ok_ff;
   logic signed [bspv_pkg::DataWidth-1:0] rsp_value_ff;
   logic [bspv_pkg::CapWidth-1:0]         rsp_depth_ff;

   logic signed [bspv_pkg::DataWidth-1:0] cell_value [DEPTH];
   bspv_pkg::shift_type                   shift;
   bspv_pkg::check_type                   check;
   logic                                  pass;
   logic                                  accept;
   logic                                  full;
   logic                                  push_ok;
   logic                                  pop_ok;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign check.mode          = mode_ff;
   assign check.range_min     = range_min_ff;
   assign check.range_max     = range_max_ff;
   assign check.last_accepted = last_ff;

   bspv_validate u_validate (
      .check (check),
      .value (req_bus.push_value),
      .pass  (pass)
   );

   // full at the configured capacity or at the physical depth, whichever is lower
   assign full = (CmpWidth'(top_ff) >= CmpWidth'(capacity_ff)) ||
                 (top_ff == CountWidth'(DEPTH));

   assign push_ok = !req_bus.op && !full && pass;
   assign pop_ok  = req_bus.op && (top_ff != '0);

   assign shift.push = accept && push_ok;
   assign shift.pop  = accept && pop_ok;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [bspv_pkg::DataWidth-1:0] above;
      logic signed [bspv_pkg::DataWidth-1:0] below;
      if (i == 0) begin : g_first
         assign above = req_bus.push_value;
      end else begin : g_mid_up
         assign above = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign below = '0;
      end else begin : g_mid_dn
         assign below = cell_value[i+1];
      end
      bspv_cell u_cell (
         .clock    (clock),
         .shift    (shift),
         .above_in (above),
         .below_in (below),
         .value    (cell_value[i])
      );
   end

   always_comb begin
      top_in = top_ff;
      if (shift.push) begin
         top_in = top_ff + CountWidth'(1);
      end else if (shift.pop) begin
         top_in = top_ff - CountWidth'(1);
      end
   end

   always_comb begin
      last_in = last_ff;
      if (csr_we && (csr_index == bspv_pkg::REG_FLOOR_START)) begin
         last_in = csr_wdata;
      end else if (shift.push && (mode_ff == bspv_pkg::MODE_MONO)) begin
         last_in = req_bus.push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= bspv_pkg::MODE_NONE;
         range_min_ff <= MinValue;
         range_max_ff <= MaxValue;
         capacity_ff  <= bspv_pkg::CapWidth'(256);
         last_ff      <= MinValue;
         top_ff       <= '0;
      end else begin
         last_ff <= last_in;
         top_ff  <= top_in;
         if (csr_we) begin
            case (csr_index)
               bspv_pkg::REG_VALIDATE_MODE: mode_ff <= csr_wdata[bspv_pkg::ModeWidth-1:0];
               bspv_pkg::REG_RANGE_MIN:     range_min_ff <= csr_wdata;
               bspv_pkg::REG_RANGE_MAX:     range_max_ff <= csr_wdata;
               bspv_pkg::REG_CAPACITY:      capacity_ff <= csr_wdata[bspv_pkg::CapWidth-1:0];
               default: ;  // floor handled with last_ff; other indexes ignored
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // depth never exceeds the largest capacity, so it fits the result field
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff    <= push_ok || pop_ok;
         rsp_value_ff <= pop_ok ? cell_value[0] : '0;
         rsp_depth_ff <= bspv_pkg::CapWidth'(top_in);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.ok           = rsp_ok_ff;
   assign rsp_bus.popped_value = rsp_value_ff;
   assign rsp_bus.depth_after  = rsp_depth_ff;

endmodule
